[rtl/urrf_pkg.sv]
// Shared constants, types and a pointer helper function for the receive ring FIFO.
package urrf_pkg;

    // Ring geometry.
    localparam int unsigned DEPTH = 2048;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BYTE_W = 8;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [BYTE_W-1:0] t_byte;

    // Operation codes carried by each input word.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_TAP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an input word is taken this cycle
        logic capture;  // memory read data is valid, load the result register
    } t_dp_cmd;

    // Advance a ring pointer, wrapping from the last entry to zero.
    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

endpackage

[rtl/urrf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module urrf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/urrf_ctrl.sv]
// Handshake controller: sequences each word through memory read and result hold.
module urrf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output urrf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_ready;
    logic   w_accept;

    // A new word may enter when idle, or when the held result leaves this cycle.
    assign w_ready  = (r_state == S_IDLE) || ((r_state == S_HOLD) && i_out_ready);
    assign w_accept = i_in_valid && w_ready;

    // Next state.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state     = S_HOLD;
                n_out_valid = 1'b1;
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = w_accept ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = w_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.accept  = w_accept;
    assign o_cmd.capture = (r_state == S_READ);

endmodule

[rtl/urrf_dp.sv]
// Datapath: ring pointers, status flags, byte store and result register.
module urrf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urrf_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_rx_byte,
    output logic [7:0]        o_read_byte,
    output logic              o_read_valid,
    output logic [7:0]        o_echo_byte,
    output logic              o_echo_valid,
    output logic              o_push_dropped,
    output logic              o_is_empty,
    output logic              o_is_full,
    output logic              o_overflowed
);

    urrf_pkg::t_ptr r_wr_ptr, n_wr_ptr;
    urrf_pkg::t_ptr r_rd_ptr, n_rd_ptr;
    urrf_pkg::t_ptr r_tap_ptr, n_tap_ptr;
    logic           r_empty, n_empty;
    logic           r_ovf, n_ovf;

    logic           w_full;
    logic           w_we;
    logic           w_re;
    urrf_pkg::t_ptr w_raddr;
    urrf_pkg::t_byte w_rdata;

    logic           n_read_valid, n_echo_valid, n_dropped;
    urrf_pkg::t_byte n_echo_byte;

    logic           r_read_valid, r_echo_valid, r_dropped, r_is_empty, r_is_full, r_ovf_out;
    urrf_pkg::t_byte r_echo_byte, r_read_byte;

    assign w_full = (r_wr_ptr == r_rd_ptr) && !r_empty;

    // Operation decode and next pointer and flag values.
    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_tap_ptr    = r_tap_ptr;
        n_empty      = r_empty;
        n_ovf        = r_ovf;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_raddr      = r_rd_ptr;
        n_read_valid = 1'b0;
        n_echo_valid = 1'b0;
        n_echo_byte  = '0;
        n_dropped    = 1'b0;
        unique case (urrf_pkg::t_op'(i_op))
            urrf_pkg::OP_PUSH: begin
                n_echo_valid = 1'b1;
                n_echo_byte  = i_rx_byte;
                if (w_full) begin
                    n_ovf     = 1'b1;
                    n_dropped = 1'b1;
                end else begin
                    w_we     = i_cmd.accept;
                    n_wr_ptr = urrf_pkg::ptr_next(r_wr_ptr);
                    n_empty  = 1'b0;
                end
            end
            urrf_pkg::OP_POP: begin
                if (!r_empty) begin
                    w_re         = i_cmd.accept;
                    w_raddr      = r_rd_ptr;
                    n_read_valid = 1'b1;
                    n_rd_ptr     = urrf_pkg::ptr_next(r_rd_ptr);
                    if (n_rd_ptr == r_wr_ptr) begin
                        n_empty = 1'b1;
                    end
                end
            end
            urrf_pkg::OP_TAP: begin
                if (r_tap_ptr != r_wr_ptr) begin
                    w_re         = i_cmd.accept;
                    w_raddr      = r_tap_ptr;
                    n_read_valid = 1'b1;
                    n_tap_ptr    = urrf_pkg::ptr_next(r_tap_ptr);
                end
            end
            urrf_pkg::OP_CLEAR: begin
                n_ovf = 1'b0;
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase
    end

    // Byte store.
    urrf_ram #(
        .WIDTH(urrf_pkg::BYTE_W),
        .DEPTH(urrf_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_rx_byte),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Pointers and flags update on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_tap_ptr <= '0;
            r_empty   <= 1'b1;
            r_ovf     <= 1'b0;
        end else if (i_cmd.accept) begin
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_tap_ptr <= n_tap_ptr;
            r_empty   <= n_empty;
            r_ovf     <= n_ovf;
        end
    end

    // Result fields known at accept time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_read_valid <= n_read_valid;
            r_echo_valid <= n_echo_valid;
            r_echo_byte  <= n_echo_byte;
            r_dropped    <= n_dropped;
            r_is_empty   <= n_empty;
            r_is_full    <= !n_empty && (n_wr_ptr == n_rd_ptr);
            r_ovf_out    <= n_ovf;
        end
    end

    // The read byte arrives from memory in the cycle after acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_read_byte <= r_read_valid ? w_rdata : '0;
        end
    end

    assign o_read_byte    = r_read_byte;
    assign o_read_valid   = r_read_valid;
    assign o_echo_byte    = r_echo_byte;
    assign o_echo_valid   = r_echo_valid;
    assign o_push_dropped = r_dropped;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;
    assign o_overflowed   = r_ovf_out;

endmodule

[rtl/uart_rx_ring_fifo_with_tap.sv]
// Top level of the receive byte ring FIFO with a second tap reader.
//
//  Channel | Handshake                 | Word contents
//  --------+---------------------------+--------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_op, i_rx_byte
//  output  | o_out_valid / i_out_ready | o_read_byte, o_read_valid, o_echo_byte,
//          |                           | o_echo_valid, o_push_dropped, o_is_empty,
//          |                           | o_is_full, o_overflowed
//
// A result is offered once the controller reaches S_HOLD: the byte store read
// is registered at acceptance and the result register loads in the next cycle.
// A new word is taken in the same cycle as the held result leaves, and none is
// taken while a read is under way. A stalled output holds the result and the
// input stays blocked. Reset is synchronous and active low; the byte store is
// not cleared and needs no clearing pass.
module uart_rx_ring_fifo_with_tap (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_byte,
    output logic       o_read_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_echo_valid,
    output logic       o_push_dropped,
    output logic       o_is_empty,
    output logic       o_is_full,
    output logic       o_overflowed
);

    urrf_pkg::t_dp_cmd w_cmd;

    // Handshake sequencing.
    urrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd)
    );

    // Storage and result formation.
    urrf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .o_read_byte   (o_read_byte),
        .o_read_valid  (o_read_valid),
        .o_echo_byte   (o_echo_byte),
        .o_echo_valid  (o_echo_valid),
        .o_push_dropped(o_push_dropped),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_overflowed  (o_overflowed)
    );

endmodule

[rtl/urrf_chk.sv]
// Port-level checker for the receive ring FIFO, bound to the top level.
module urrf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_op,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_byte,
    input logic       o_read_valid,
    input logic [7:0] o_echo_byte,
    input logic       o_echo_valid,
    input logic       o_push_dropped,
    input logic       o_is_empty,
    input logic       o_is_full,
    input logic       o_overflowed
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // A word never flags both a read and a push.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_echo_valid))
        else $error("read and echo flagged in one word");

    // Full and empty exclude each other.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_full |-> !o_is_empty)
        else $error("full and empty at once");

    // A dropped push leaves the ring full with overflow set.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_dropped |-> o_overflowed && o_is_full && o_echo_valid)
        else $error("dropped push without full and overflow");

    // No byte is shown when nothing was read.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_byte == 8'd0)
        else $error("read byte not zero on a word without a read");

endmodule

bind uart_rx_ring_fifo_with_tap urrf_chk u_urrf_chk (.*);
